// ===== hw/rtl/vra_pkg.sv =====
package vra_pkg;

  localparam int PAGE_W = 52;
  localparam int FLAG_W = 12;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PHYS = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic [PAGE_W-1:0] RESET_BASE  = 52'd1;
  localparam logic [PAGE_W-1:0] RESET_COUNT = 52'd4503049871556576;

  localparam int IN_W  = 120;
  localparam int OUT_W = 112;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] length;
    logic [KIND_W-1:0] kind;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic       load;
    logic       start;
    logic       p1_chk;
    logic       restart;
    logic       split;
    logic       emit_en;
    logic [1:0] emit_sel;
    logic       step;
    logic       set_zero;
    logic       set_nofit;
    logic       commit;
    logic       publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_done;
    logic zero_len;
    logic is_free;
    logic pick_found;
    logic out_busy;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/virtual_region_allocator.sv =====
// One request at a time. An allocate makes one pass over the table to pick a region and
// then a pass that rewrites the table; a free makes only the rewriting pass. No fit and
// zero length end after the first pass or sooner.
// The next request is accepted in the cycle after the result is posted; a new result waits
// until the previous one is taken. Reset (synchronous, active high) sets one free region
// of 4503049871556576 pages at page 1; a configuration write rebuilds it from the space.
module virtual_region_allocator #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [vra_pkg::PAGE_W-1:0] cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // req_page[51:0], req_pages[103:52], use_kind[104], map_flags[116:105]
  input  logic [vra_pkg::IN_W-1:0]   s_tdata,
  // cmd[0]
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status[1:0], result_page[53:2], released_pages[105:54]
  output logic [vra_pkg::OUT_W-1:0]  m_tdata
);

  vra_pkg::ctl_cmd_t cmd;
  vra_pkg::ctl_sts_t sts;
  logic [1:0]                 out_status;
  logic [vra_pkg::PAGE_W-1:0] out_page, out_released;

  vra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  vra_dp #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cmd(s_tuser), .in_page(s_tdata[51:0]), .in_pages(s_tdata[103:52]),
    .in_use_kind(s_tdata[104]), .in_flags(s_tdata[116:105]),
    .cmd(cmd), .sts(sts),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_status(out_status), .out_page(out_page), .out_released(out_released)
  );

  assign m_tdata = {6'b0, out_released, out_page, out_status};

endmodule

// ===== hw/rtl/vra_ram.sv =====
module vra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/vra_ctrl.sv =====
module vra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vra_pkg::ctl_sts_t   sts,
  output vra_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_P1_RD    = 11'b00000000100,
    S_P1_CHK   = 11'b00000001000,
    S_P2_RD    = 11'b00000010000,
    S_P2_SPLIT = 11'b00000100000,
    S_EMIT0    = 11'b00001000000,
    S_EMIT1    = 11'b00010000000,
    S_EMIT2    = 11'b00100000000,
    S_FLUSH    = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.start = 1'b1;
        if (sts.zero_len) begin
          cmd.set_zero = 1'b1;
          state_next = S_DONE;
        end else if (sts.is_free) begin
          state_next = S_P2_RD;
        end else begin
          state_next = S_P1_RD;
        end
      end
      S_P1_RD: begin
        if (sts.idx_done) begin
          if (sts.pick_found) begin
            cmd.restart = 1'b1;
            state_next = S_P2_RD;
          end else begin
            cmd.set_nofit = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          state_next = S_P1_CHK;
        end
      end
      S_P1_CHK: begin
        cmd.p1_chk = 1'b1;
        cmd.step = 1'b1;
        state_next = S_P1_RD;
      end
      S_P2_RD: begin
        state_next = sts.idx_done ? S_FLUSH : S_P2_SPLIT;
      end
      S_P2_SPLIT: begin
        cmd.split = 1'b1;
        state_next = S_EMIT0;
      end
      S_EMIT0: begin
        cmd.emit_en = 1'b1;
        cmd.emit_sel = 2'd0;
        state_next = S_EMIT1;
      end
      S_EMIT1: begin
        cmd.emit_en = 1'b1;
        cmd.emit_sel = 2'd1;
        state_next = S_EMIT2;
      end
      S_EMIT2: begin
        cmd.emit_en = 1'b1;
        cmd.emit_sel = 2'd2;
        cmd.step = 1'b1;
        state_next = S_P2_RD;
      end
      S_FLUSH: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/vra_dp.sv =====
module vra_dp #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [vra_pkg::PAGE_W-1:0]  cfg_data,
  input  logic                        in_cmd,
  input  logic [vra_pkg::PAGE_W-1:0]  in_page,
  input  logic [vra_pkg::PAGE_W-1:0]  in_pages,
  input  logic                        in_use_kind,
  input  logic [vra_pkg::FLAG_W-1:0]  in_flags,
  input  vra_pkg::ctl_cmd_t           cmd,
  output vra_pkg::ctl_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [vra_pkg::PAGE_W-1:0]  out_page,
  output logic [vra_pkg::PAGE_W-1:0]  out_released
);

  localparam int PW = vra_pkg::PAGE_W;
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  logic [PW-1:0]          base, pcount;
  logic                   init_mode, bank;
  logic [CW-1:0]          tbl_count, idx, nx, pick_h, pick_f;
  logic                   req_cmd;
  logic [PW-1:0]          req_page, req_pages, ff_place, released;
  logic [1:0]             req_kind;
  logic [vra_pkg::FLAG_W-1:0] req_flags;
  logic                   hint_found, ff_found, over, em_rel;
  logic [1:0]             res_status;
  vra_pkg::entry_t        em [3];
  vra_pkg::entry_t        pend, rd_ent, init_ent, cur;
  logic [vra_pkg::ENT_W-1:0] rdata0, rdata1;

  logic [PW:0]   avail, off, off_end, e, pn, rend, lo, hi, pend_end;
  logic [PW-1:0] clip, place;
  logic [CW-1:0] cnt_eff, pick_idx;
  logic          hint_ok, ff_ok, aff, merge;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  vra_pkg::entry_t em_n [3];

  assign avail = {1'b1, {PW{1'b0}}} - {1'b0, base};
  assign clip = ({1'b0, pcount} > avail) ? avail[PW-1:0] : pcount;
  assign init_ent = '{start: base, length: clip, kind: vra_pkg::KIND_FREE, flags: '0};
  assign cnt_eff = init_mode ? CW'(clip != '0) : tbl_count;

  assign rd_ent = init_mode ? init_ent : vra_pkg::entry_t'(bank ? rdata1 : rdata0);

  assign place = hint_found ? req_page : ff_place;
  assign pick_idx = hint_found ? pick_h : pick_f;

  assign sts.idx_done   = (idx == cnt_eff);
  assign sts.zero_len   = (req_pages == '0);
  assign sts.is_free    = (req_cmd == vra_pkg::CMD_FREE);
  assign sts.pick_found = hint_found | ff_found;
  assign sts.out_busy   = out_valid;

  assign off = {1'b0, req_page} - {1'b0, rd_ent.start};
  assign off_end = off + {1'b0, req_pages};
  assign hint_ok = (req_page != '0) && (rd_ent.kind == vra_pkg::KIND_FREE)
                   && (rd_ent.start <= req_page) && (off < {1'b0, rd_ent.length})
                   && (off_end <= {1'b0, rd_ent.length});
  assign ff_ok = (rd_ent.kind == vra_pkg::KIND_FREE) && (rd_ent.length >= req_pages);

  assign e = {1'b0, rd_ent.start} + {1'b0, rd_ent.length};
  assign pn = {1'b0, place} + {1'b0, req_pages};
  assign rend = {1'b0, req_page} + {1'b0, req_pages};
  assign aff = (rd_ent.kind != vra_pkg::KIND_FREE) && (e > {1'b0, req_page})
               && ({1'b0, rd_ent.start} < rend);
  assign lo = (rd_ent.start > req_page) ? {1'b0, rd_ent.start} : {1'b0, req_page};
  assign hi = (e < rend) ? e : rend;

  always_comb begin
    em_n[0] = rd_ent;
    em_n[1] = rd_ent;
    em_n[2] = rd_ent;
    em_n[1].length = '0;
    em_n[2].length = '0;
    if (req_cmd == vra_pkg::CMD_ALLOC) begin
      if (idx == pick_idx) begin
        em_n[0] = '{start: rd_ent.start, length: place - rd_ent.start,
                    kind: vra_pkg::KIND_FREE, flags: '0};
        em_n[1] = '{start: place, length: req_pages, kind: req_kind, flags: req_flags};
        em_n[2] = '{start: pn[PW-1:0], length: PW'(e - pn),
                    kind: vra_pkg::KIND_FREE, flags: '0};
      end
    end else if (aff) begin
      em_n[0].length = PW'(lo - {1'b0, rd_ent.start});
      em_n[1] = '{start: lo[PW-1:0], length: PW'(hi - lo),
                  kind: vra_pkg::KIND_FREE, flags: '0};
      em_n[2].start = hi[PW-1:0];
      em_n[2].length = PW'(e - hi);
    end
  end

  assign cur = em[cmd.emit_sel];
  assign pend_end = {1'b0, pend.start} + {1'b0, pend.length};
  assign merge = (cur.kind == vra_pkg::KIND_FREE) && (nx != '0)
                 && (pend.kind == vra_pkg::KIND_FREE) && (pend_end == {1'b0, cur.start});

  always_comb begin
    wr_en = 1'b0;
    if (cmd.emit_en && cur.length != '0 && !over && !merge
        && nx != CW'(MAX_REGIONS) && nx != '0) begin
      wr_en = 1'b1;
    end
    if (cmd.commit && nx != '0 && !over) begin
      wr_en = 1'b1;
    end
  end
  assign wr_addr = IW'(nx - CW'(1));

  vra_ram #(.WIDTH(vra_pkg::ENT_W), .DEPTH(MAX_REGIONS)) u_ram0 (
    .clk(clk), .we(wr_en & bank), .waddr(wr_addr), .wdata(pend),
    .raddr(idx[IW-1:0]), .rdata(rdata0)
  );

  vra_ram #(.WIDTH(vra_pkg::ENT_W), .DEPTH(MAX_REGIONS)) u_ram1 (
    .clk(clk), .we(wr_en & ~bank), .waddr(wr_addr), .wdata(pend),
    .raddr(idx[IW-1:0]), .rdata(rdata1)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd <= in_cmd;
      req_page <= in_page;
      req_pages <= in_pages;
      req_kind <= in_use_kind ? vra_pkg::KIND_PHYS : vra_pkg::KIND_ANON;
      req_flags <= in_flags;
    end
    if (cmd.p1_chk) begin
      if (!hint_found && hint_ok) begin
        pick_h <= idx;
      end
      if (!ff_found && ff_ok) begin
        pick_f <= idx;
        ff_place <= rd_ent.start;
      end
    end
    if (cmd.split) begin
      em <= em_n;
      em_rel <= (req_cmd == vra_pkg::CMD_FREE) && aff;
    end
    if (cmd.start) begin
      released <= '0;
    end else if (cmd.emit_en && cmd.emit_sel == 2'd1 && em_rel) begin
      released <= released + cur.length;
    end
    if (cmd.emit_en && cur.length != '0 && !over) begin
      if (merge) begin
        pend.length <= pend.length + cur.length;
      end else if (nx != CW'(MAX_REGIONS)) begin
        pend <= '{start: cur.start, length: cur.length, kind: cur.kind,
                  flags: (cur.kind == vra_pkg::KIND_FREE) ? {vra_pkg::FLAG_W{1'b0}}
                                                          : cur.flags};
      end
    end
    if (cmd.publish) begin
      out_status <= res_status;
      out_page <= (req_cmd == vra_pkg::CMD_FREE) ? req_page
                : ((res_status == vra_pkg::ST_OK) ? place : '0);
      out_released <= ((req_cmd == vra_pkg::CMD_FREE) && (res_status == vra_pkg::ST_OK))
                      ? released : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= vra_pkg::RESET_BASE;
      pcount <= vra_pkg::RESET_COUNT;
      init_mode <= 1'b1;
      bank <= 1'b0;
      tbl_count <= '0;
      idx <= '0;
      nx <= '0;
      over <= 1'b0;
      hint_found <= 1'b0;
      ff_found <= 1'b0;
      res_status <= vra_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_mode <= 1'b1;
        if (cfg_index == vra_pkg::CFG_BASE) begin
          base <= cfg_data;
        end else begin
          pcount <= cfg_data;
        end
      end
      if (cmd.start || cmd.restart) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= idx + CW'(1);
      end
      if (cmd.start) begin
        nx <= '0;
        over <= 1'b0;
        hint_found <= 1'b0;
        ff_found <= 1'b0;
      end
      if (cmd.p1_chk) begin
        if (hint_ok) begin
          hint_found <= 1'b1;
        end
        if (ff_ok) begin
          ff_found <= 1'b1;
        end
      end
      if (cmd.emit_en && cur.length != '0 && !over && !merge) begin
        if (nx == CW'(MAX_REGIONS)) begin
          over <= 1'b1;
        end else begin
          nx <= nx + CW'(1);
        end
      end
      if (cmd.set_zero) begin
        res_status <= vra_pkg::ST_ZERO;
      end else if (cmd.set_nofit) begin
        res_status <= vra_pkg::ST_NOFIT;
      end else if (cmd.commit) begin
        res_status <= over ? vra_pkg::ST_FULL : vra_pkg::ST_OK;
      end else if (cmd.start) begin
        res_status <= vra_pkg::ST_OK;
      end
      if (cmd.commit && !over) begin
        bank <= ~bank;
        tbl_count <= nx;
        init_mode <= 1'b0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/vra_checker.sv =====
module vra_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [vra_pkg::OUT_W-1:0] m_tdata
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_fail_no_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != vra_pkg::ST_OK |-> m_tdata[105:54] == '0)
    else $error("released pages on failed request");

  a_nofit_page: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == vra_pkg::ST_NOFIT |-> m_tdata[53:2] == '0)
    else $error("page granted on failed allocate");

endmodule

bind virtual_region_allocator vra_checker u_chk (.*);

// ===== test/virtual_region_allocator_test.sv =====
`timescale 1ns / 1ps

module virtual_region_allocator_test;

  localparam int NREG = 64;
  localparam int NSCR = NREG + 2;
  localparam int PW = vra_pkg::PAGE_W;
  localparam bit [63:0] PAGE_TOP = 64'h0010_0000_0000_0000;
  localparam bit [63:0] PAGE_MAX = PAGE_TOP - 1;
  localparam int DRAIN_CYCLES = 7 * NREG + 64;

  typedef struct {
    logic                       cmd;
    logic [PW-1:0]              page;
    logic [PW-1:0]              pages;
    logic                       kind;
    logic [vra_pkg::FLAG_W-1:0] flags;
  } request_t;

  typedef struct {
    logic [1:0]    status;
    logic [PW-1:0] rpage;
    logic [PW-1:0] released;
  } answer_t;

  logic                       clk = 0;
  logic                       rst = 1;
  logic                       cfg_we = 0;
  logic                       cfg_index = vra_pkg::CFG_BASE;
  logic [PW-1:0]              cfg_data = '0;
  logic                       s_tvalid = 0;
  logic                       s_tready;
  logic [vra_pkg::IN_W-1:0]   s_tdata = '0;
  logic                       s_tuser = vra_pkg::CMD_ALLOC;
  logic                       m_tvalid;
  logic                       m_tready = 0;
  logic [vra_pkg::OUT_W-1:0]  m_tdata;

  virtual_region_allocator #(.MAX_REGIONS(NREG)) dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // region table mirror
  bit [63:0] rg_start [NREG];
  bit [63:0] rg_len [NREG];
  bit [1:0]  rg_kind [NREG];
  bit [11:0] rg_flags [NREG];
  int        rg_count;
  bit [63:0] nx_start [NSCR];
  bit [63:0] nx_len [NSCR];
  bit [1:0]  nx_kind [NSCR];
  bit [11:0] nx_flags [NSCR];
  int        nx_count;
  bit        nx_over;
  bit [63:0] space_base, space_count, space_span;

  request_t  pending_reqs [$];
  answer_t   pending_answers [$];
  request_t  cur_req;
  int        errors = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_req = 0;
  int        hold_left = 0;

  function automatic void rebuild_table();
    bit [63:0] cnt;
    cnt = space_count;
    if (cnt > PAGE_TOP - space_base) cnt = PAGE_TOP - space_base;
    space_span = cnt;
    for (int i = 0; i < NREG; i++) begin
      rg_start[i] = 0; rg_len[i] = 0; rg_kind[i] = vra_pkg::KIND_FREE; rg_flags[i] = 0;
    end
    rg_count = 0;
    if (cnt != 0) begin
      rg_start[0] = space_base;
      rg_len[0] = cnt;
      rg_count = 1;
    end
  endfunction

  function automatic void put_region(bit [63:0] s, bit [63:0] l, bit [1:0] k, bit [11:0] f);
    if (l == 0 || nx_over) return;
    if (k == vra_pkg::KIND_FREE && nx_count > 0 && nx_kind[nx_count-1] == vra_pkg::KIND_FREE &&
        nx_start[nx_count-1] + nx_len[nx_count-1] == s) begin
      nx_len[nx_count-1] += l;
      return;
    end
    if (nx_count >= NSCR) begin
      nx_over = 1;
      return;
    end
    nx_start[nx_count] = s;
    nx_len[nx_count] = l;
    nx_kind[nx_count] = k;
    nx_flags[nx_count] = (k == vra_pkg::KIND_FREE) ? 12'd0 : f;
    nx_count++;
  endfunction

  function automatic bit swap_table();
    if (nx_over || nx_count > NREG) return 0;
    for (int i = 0; i < NREG; i++) begin
      if (i < nx_count) begin
        rg_start[i] = nx_start[i]; rg_len[i] = nx_len[i];
        rg_kind[i] = nx_kind[i]; rg_flags[i] = nx_flags[i];
      end else begin
        rg_start[i] = 0; rg_len[i] = 0; rg_kind[i] = vra_pkg::KIND_FREE; rg_flags[i] = 0;
      end
    end
    rg_count = nx_count;
    return 1;
  endfunction

  function automatic answer_t allocate_or_release(request_t r);
    answer_t   a;
    bit [63:0] p, n, place, s, l, e, endp, lo, hi, rel;
    bit [1:0]  kind;
    int        pick;
    p = r.page;
    n = r.pages;
    a.status = vra_pkg::ST_OK;
    a.rpage = (r.cmd == vra_pkg::CMD_FREE) ? r.page : '0;
    a.released = '0;
    if (n == 0) begin
      a.status = vra_pkg::ST_ZERO;
      return a;
    end
    nx_count = 0;
    nx_over = 0;
    if (r.cmd == vra_pkg::CMD_ALLOC) begin
      kind = r.kind ? vra_pkg::KIND_PHYS : vra_pkg::KIND_ANON;
      pick = -1;
      place = 0;
      if (p != 0)
        for (int i = 0; i < rg_count && pick < 0; i++) begin
          s = rg_start[i]; l = rg_len[i];
          if (rg_kind[i] == vra_pkg::KIND_FREE && s <= p && p - s < l && (p - s) + n <= l) begin
            pick = i;
            place = p;
          end
        end
      if (pick < 0)
        for (int i = 0; i < rg_count && pick < 0; i++)
          if (rg_kind[i] == vra_pkg::KIND_FREE && rg_len[i] >= n) begin
            pick = i;
            place = rg_start[i];
          end
      if (pick < 0) begin
        a.status = vra_pkg::ST_NOFIT;
        return a;
      end
      for (int i = 0; i < rg_count; i++) begin
        s = rg_start[i]; l = rg_len[i];
        if (i == pick) begin
          put_region(s, place - s, vra_pkg::KIND_FREE, 12'd0);
          put_region(place, n, kind, r.flags);
          put_region(place + n, s + l - place - n, vra_pkg::KIND_FREE, 12'd0);
        end else
          put_region(s, l, rg_kind[i], rg_flags[i]);
      end
      if (!swap_table()) a.status = vra_pkg::ST_FULL;
      else a.rpage = place[PW-1:0];
    end else begin
      endp = p + n;
      rel = 0;
      for (int i = 0; i < rg_count; i++) begin
        s = rg_start[i]; l = rg_len[i]; e = s + l;
        if (rg_kind[i] == vra_pkg::KIND_FREE || e <= p || s >= endp)
          put_region(s, l, rg_kind[i], rg_flags[i]);
        else begin
          lo = s > p ? s : p;
          hi = e < endp ? e : endp;
          put_region(s, lo - s, rg_kind[i], rg_flags[i]);
          put_region(lo, hi - lo, vra_pkg::KIND_FREE, 12'd0);
          rel += hi - lo;
          put_region(hi, e - hi, rg_kind[i], rg_flags[i]);
        end
      end
      if (!swap_table()) a.status = vra_pkg::ST_FULL;
      else a.released = rel[PW-1:0];
    end
    return a;
  endfunction

  function automatic bit [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t make_req(bit cmd, bit [63:0] page, bit [63:0] pages,
                                        bit kind, bit [11:0] flags);
    request_t r;
    r.cmd = cmd; r.page = page[PW-1:0]; r.pages = pages[PW-1:0];
    r.kind = kind; r.flags = flags;
    return r;
  endfunction

  // mostly sized to the current space so that allocations fragment the table
  function automatic request_t random_req();
    int        sel;
    bit [63:0] span, page, pages;
    sel = $urandom_range(99);
    span = (space_span == 0) ? 64'd1 : space_span;
    page = space_base + rnd64() % span;
    if (sel < 3)
      return make_req(1'($urandom_range(1)), rnd64(), 64'd0, 1'($urandom_range(1)),
                      12'($urandom_range(4095)));
    if (sel < 10)
      return make_req(1'($urandom_range(1)), rnd64(), rnd64(), 1'($urandom_range(1)),
                      12'($urandom_range(4095)));
    if (sel < 58) begin
      pages = ($urandom_range(9) == 0) ? 64'd1 + rnd64() % span
                                       : 64'($urandom_range(1, 24));
      if ($urandom_range(3) == 0) page = 0;
      return make_req(vra_pkg::CMD_ALLOC, page, pages, 1'($urandom_range(1)),
                      12'($urandom_range(4095)));
    end
    pages = ($urandom_range(9) == 0) ? rnd64() % PAGE_TOP : 64'($urandom_range(1, 64));
    return make_req(vra_pkg::CMD_FREE, page, pages, 1'($urandom_range(1)),
                    12'($urandom_range(4095)));
  endfunction

  task automatic write_reg(logic idx, bit [63:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[PW-1:0];
    if (idx == vra_pkg::CFG_BASE) space_base = val & PAGE_MAX;
    else space_count = val & PAGE_MAX;
    rebuild_table();
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || pending_answers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(bit [63:0] base, bit [63:0] count, int n, int idle, int stall);
    write_reg(vra_pkg::CFG_BASE, base);
    write_reg(vra_pkg::CFG_COUNT, count);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
    wait_drained();
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) pending_answers.push_back(allocate_or_release(cur_req));
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        s_tvalid <= 1;
        s_tdata <= {3'b000, cur_req.flags, cur_req.kind, cur_req.pages, cur_req.page};
        s_tuser <= cur_req.cmd;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 4000;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // checker
  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%t: unexpected transfer, expected none, actual %h", $realtime, m_tdata);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $display("%t: status expected %0d actual %0d", $realtime, want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[53:2] !== want.rpage) begin
          $display("%t: result_page expected %h actual %h", $realtime, want.rpage,
                   m_tdata[53:2]);
          errors++;
        end
        if (m_tdata[105:54] !== want.released) begin
          $display("%t: released_pages expected %h actual %h", $realtime, want.released,
                   m_tdata[105:54]);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** virtual_region_allocator: FAILED **");
    $finish;
  end

  initial begin
    space_base = 64'(vra_pkg::RESET_BASE);
    space_count = 64'(vra_pkg::RESET_COUNT);
    rebuild_table();
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: reset space
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'd5, 64'd0, 1'b0, 12'h000));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, PAGE_MAX, 64'd0, 1'b1, 12'hFFF));
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'd0, PAGE_MAX, 1'b1, 12'hFFF));
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'd0, 64'd1, 1'b0, 12'h001));
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, PAGE_MAX, 64'd1, 1'b1, 12'hFFF));
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'h1000, 64'h20000, 1'b0, 12'hABC));
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'h1000, 64'd4, 1'b1, 12'h555));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'h800, 64'h1000, 1'b0, 12'h000));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'h1100, 64'd16, 1'b0, 12'h000));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'h1000, 64'h20000, 1'b0, 12'h000));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'hFFF8000000000, PAGE_MAX, 1'b0,
                                    12'h000));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'd0, PAGE_MAX, 1'b0, 12'h000));
    pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'd0, 64'(vra_pkg::RESET_COUNT),
                                    1'b1, 12'h3C3));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'd1, 64'(vra_pkg::RESET_COUNT),
                                    1'b0, 12'h000));
    wait_drained();
    // table full: scatter single pages by hint
    write_reg(vra_pkg::CFG_BASE, 64'h100);
    write_reg(vra_pkg::CFG_COUNT, 64'h200);
    for (int i = 0; i < 40; i++)
      pending_reqs.push_back(make_req(vra_pkg::CMD_ALLOC, 64'h101 + 64'(2 * i), 64'd1, i[0],
                                      12'h0F0));
    pending_reqs.push_back(make_req(vra_pkg::CMD_FREE, 64'h100, 64'h200, 1'b0, 12'h000));
    wait_drained();
    run_phase(64'h0001_0000 + 64'($urandom_range(65535)), 64'd2000, 250, 0, 0);
    run_phase(64'd0, 64'd600, 250, 53, 0);
    hold_req = 1;
    run_phase(PAGE_TOP - 64'd2048, PAGE_MAX, 250, 0, 53);
    run_phase(rnd64() & PAGE_MAX, 64'd1500, 250, 23, 23);
    run_phase(PAGE_MAX, 64'd5, 15, 23, 23);
    run_phase(rnd64() & PAGE_MAX, 64'd0, 10, 0, 0);
    run_phase(64'(vra_pkg::RESET_BASE), PAGE_MAX, 20, 53, 53);
    if (errors == 0) begin
      $display("** virtual_region_allocator: PASSED **");
    end else begin
      $display("** virtual_region_allocator: FAILED **");
    end
    $finish;
  end

endmodule
